// File: design/drnpt_pkg.sv
// shared types and constants of the depth region nearest-point tracker
`timescale 1ns / 1ps

package drnpt_pkg;

    // field widths
    localparam int DEPTH_W    = 16;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 10;
    localparam int ELAPSED_W  = 20;
    localparam int SPEED_W    = 21;

    // divider: 16 bit difference times a 20 bit scale gives a 36 bit numerator
    localparam int NUM_W      = DEPTH_W + ELAPSED_W;
    localparam int STEP_W     = 6;

    // stream packing
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 2;
    localparam int M_PAD_W    = M_TDATA_W - DEPTH_W - SPEED_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CEILING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DISTANCE = 3'd6;

    // register reset values
    localparam logic [DEPTH_W-1:0] RST_DEPTH_FLOOR   = 16'd300;
    localparam logic [DEPTH_W-1:0] RST_DEPTH_CEILING = 16'd3000;
    localparam logic [ROW_W-1:0]   RST_WINDOW_TOP    = 10'd100;
    localparam logic [ROW_W-1:0]   RST_WINDOW_BOTTOM = 10'd350;
    localparam logic [COL_W-1:0]   RST_WINDOW_LEFT   = 11'd100;
    localparam logic [COL_W-1:0]   RST_WINDOW_RIGHT  = 11'd540;
    localparam logic [DEPTH_W-1:0] RST_OPEN_DISTANCE = 16'd400;

    // speed scale (us per s) and saturation limit
    localparam logic [ELAPSED_W-1:0] SPEED_SCALE = 20'd1000000;
    localparam logic [ELAPSED_W-1:0] SPEED_LIMIT = 20'd1000000;

    // controller states
    typedef enum logic [3:0] {
        S_PIXEL = 4'b0001,
        S_MULT  = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic pixel_accept;
        logic mult_load;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// File: design/drnpt_ctrl.sv
// frame controller: pixel acceptance and sequencing of the speed divide
`timescale 1ns / 1ps

module drnpt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tlast,
    output logic                 s_axis_tready,
    input  drnpt_pkg::t_dp_status i_status,
    output drnpt_pkg::t_dp_cmd   o_cmd
);
    import drnpt_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_accept;

    assign s_axis_tready = (r_state == S_PIXEL);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_PIXEL: begin
                o_cmd.pixel_accept = w_accept;
                if (w_accept && s_axis_tlast) begin
                    n_state = S_MULT;
                end
            end
            S_MULT: begin
                o_cmd.mult_load = 1'b1;
                n_step          = STEP_W'(NUM_W - 1);
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_PIXEL;
                end
            end
            default: begin
                n_state = S_PIXEL;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PIXEL;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

`ifndef SYNTH
    // last pixel of a frame always starts the speed computation
    a_end_starts_mult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pixel_accept && s_axis_tlast |=> r_state == S_MULT)
        else $error("frame end did not start the multiply");

    // the datapath gets at most one command a cycle
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

    // divide step counter stays within the numerator width
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_step <= STEP_W'(NUM_W - 1))
        else $error("divide step counter out of range");
`endif

endmodule

// File: design/drnpt_datapath.sv
// datapath: config registers, pixel test, running minimum, speed divider, output register
`timescale 1ns / 1ps

module drnpt_datapath #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [drnpt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [drnpt_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic [drnpt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [drnpt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic [drnpt_pkg::M_TUSER_W-1:0]     m_axis_tuser,
    input  drnpt_pkg::t_dp_cmd                  i_cmd,
    output drnpt_pkg::t_dp_status               o_status
);
    import drnpt_pkg::*;

    // configuration registers
    logic [DEPTH_W-1:0] r_depth_floor, r_depth_ceiling, r_open_distance;
    logic [ROW_W-1:0]   r_window_top, r_window_bottom;
    logic [COL_W-1:0]   r_window_left, r_window_right;

    // frame state
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [DEPTH_W-1:0] r_min;
    logic               r_any;
    logic [DEPTH_W-1:0] r_prev;
    logic               r_have_prev;

    // per-frame result staging
    logic [DEPTH_W-1:0]   r_nearest;
    logic                 r_found;
    logic                 r_door;
    logic                 r_neg;
    logic                 r_spd_zero;
    logic [DEPTH_W-1:0]   r_diff;
    logic [ELAPSED_W-1:0] r_elapsed;

    // divider
    logic [NUM_W-1:0]     r_work;
    logic [ELAPSED_W-1:0] r_rem;

    // output register
    logic                 r_out_valid;
    logic [DEPTH_W-1:0]   r_out_nearest;
    logic [SPEED_W-1:0]   r_out_speed;
    logic                 r_out_found;
    logic                 r_out_door;

    // combinational pixel path
    logic [DEPTH_W-1:0]   w_depth;
    logic [ELAPSED_W-1:0] w_elapsed;
    logic [COL_W-1:0]     w_col, w_col_next;
    logic [ROW_W-1:0]     w_row, w_row_next;
    logic [DEPTH_W-1:0]   w_min, w_min_new, w_nearest;
    logic                 w_any, w_any_new, w_hit;

    // divider and result path
    logic [ELAPSED_W:0]   w_rem_shift;
    logic                 w_ge;
    logic [ELAPSED_W:0]   w_rem_sub;
    logic [ELAPSED_W-1:0] w_mag;
    logic [SPEED_W-1:0]   w_speed;

    assign w_depth   = s_axis_tdata[DEPTH_W-1:0];
    assign w_elapsed = s_axis_tdata[DEPTH_W +: ELAPSED_W];

    // frame start restarts counting and the minimum before this pixel is tested
    always_comb begin
        w_col = s_axis_tuser ? '0 : r_col;
        w_row = s_axis_tuser ? '0 : r_row;
        w_min = s_axis_tuser ? '1 : r_min;
        w_any = s_axis_tuser ? 1'b0 : r_any;
    end

    // region and depth window test, running minimum
    always_comb begin
        w_hit = (w_col >= r_window_left) && (w_col < r_window_right) &&
                (w_row >= r_window_top) && (w_row < r_window_bottom) &&
                (w_depth > r_depth_floor) && (w_depth < r_depth_ceiling);
        w_min_new = (w_hit && (w_depth < w_min)) ? w_depth : w_min;
        w_any_new = w_any || w_hit;
        w_nearest = w_any_new ? w_min_new : '0;
    end

    // raster position of the next pixel
    always_comb begin
        w_col_next = w_col + 1'b1;
        w_row_next = w_row;
        if (w_col == COL_W'(FRAME_WIDTH - 1)) begin
            w_col_next = '0;
            w_row_next = (w_row == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : w_row + 1'b1;
        end
    end

    // one restoring divide step
    always_comb begin
        w_rem_shift = {r_rem, r_work[NUM_W-1]};
        w_ge        = (w_rem_shift >= {1'b0, r_elapsed});
        w_rem_sub   = w_rem_shift - {1'b0, r_elapsed};
    end

    // saturate and apply sign
    always_comb begin
        w_mag   = (r_work > NUM_W'(SPEED_LIMIT)) ? SPEED_LIMIT : r_work[ELAPSED_W-1:0];
        w_speed = {1'b0, w_mag};
        if (r_spd_zero) begin
            w_speed = '0;
        end else if (r_neg) begin
            w_speed = SPEED_W'(0) - w_speed;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_floor   <= RST_DEPTH_FLOOR;
            r_depth_ceiling <= RST_DEPTH_CEILING;
            r_window_top    <= RST_WINDOW_TOP;
            r_window_bottom <= RST_WINDOW_BOTTOM;
            r_window_left   <= RST_WINDOW_LEFT;
            r_window_right  <= RST_WINDOW_RIGHT;
            r_open_distance <= RST_OPEN_DISTANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEPTH_FLOOR:   r_depth_floor   <= i_cfg_wdata;
                CFG_DEPTH_CEILING: r_depth_ceiling <= i_cfg_wdata;
                CFG_WINDOW_TOP:    r_window_top    <= i_cfg_wdata[ROW_W-1:0];
                CFG_WINDOW_BOTTOM: r_window_bottom <= i_cfg_wdata[ROW_W-1:0];
                CFG_WINDOW_LEFT:   r_window_left   <= i_cfg_wdata[COL_W-1:0];
                CFG_WINDOW_RIGHT:  r_window_right  <= i_cfg_wdata[COL_W-1:0];
                CFG_OPEN_DISTANCE: r_open_distance <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // frame state update per accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_min       <= '1;
            r_any       <= 1'b0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
        end else if (i_cmd.pixel_accept) begin
            if (s_axis_tlast) begin
                r_col       <= '0;
                r_row       <= '0;
                r_min       <= '1;
                r_any       <= 1'b0;
                r_prev      <= w_nearest;
                r_have_prev <= 1'b1;
            end else begin
                r_col <= w_col_next;
                r_row <= w_row_next;
                r_min <= w_min_new;
                r_any <= w_any_new;
            end
        end
    end

    // capture frame result operands on the last pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.pixel_accept && s_axis_tlast) begin
            r_nearest  <= w_nearest;
            r_found    <= w_any_new;
            r_door     <= (w_nearest < r_open_distance);
            r_neg      <= (w_nearest < r_prev);
            r_diff     <= (w_nearest < r_prev) ? r_prev - w_nearest : w_nearest - r_prev;
            r_elapsed  <= w_elapsed;
            r_spd_zero <= !r_have_prev || (w_elapsed == '0);
        end
    end

    // numerator multiply, then one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mult_load) begin
            r_work <= NUM_W'(r_diff) * NUM_W'(SPEED_SCALE);
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_work <= {r_work[NUM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_rem_sub[ELAPSED_W-1:0] : w_rem_shift[ELAPSED_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_nearest <= r_nearest;
            r_out_speed   <= w_speed;
            r_out_found   <= r_found;
            r_out_door    <= r_door;
        end
    end

    assign o_status.out_free = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid     = r_out_valid;
    assign m_axis_tdata      = {{M_PAD_W{1'b0}}, r_out_speed, r_out_nearest};
    assign m_axis_tuser      = {r_out_door, r_out_found};

`ifndef SYNTH
    // an empty frame reports distance zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_out_found |-> r_out_nearest == '0)
        else $error("nearest distance nonzero without a target");

    // speed stays inside the saturation limits
    a_speed_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(r_out_speed) <= $signed({1'b0, SPEED_LIMIT})) &&
                          ($signed(r_out_speed) >= -$signed({1'b0, SPEED_LIMIT})))
        else $error("speed outside saturation range");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid || m_axis_tready)
        else $error("output register overwritten");
`endif

endmodule

// File: design/depth_roi_nearest_point_tracker_unit.sv
// top level of the depth region nearest-point tracker
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: depth_mm[15:0], elapsed_us[35:16]
//           |     |                               | tuser: frame_start, tlast: frame_end
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: nearest_mm[15:0], speed_mm_s[36:16]
//           |     |                               | tuser: target_found[0], door_open[1]
//  cfg      | in  | i_cfg_we (no wait)            | i_cfg_index, i_cfg_wdata
//
// one pixel transaction per cycle inside a frame
// after the frame_end pixel the input stalls while the controller loads the multiply, runs the
// bit-serial divider and loads the output register
// the output register holds one result; input stalls longer only if the previous result
// is still not taken when the next one is ready
// reset is synchronous, active low, and returns the config registers to their defaults
`timescale 1ns / 1ps

module depth_roi_nearest_point_tracker_unit #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [drnpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [drnpt_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // pixel stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [drnpt_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // depth_mm, elapsed_us, zero pad
    input  logic                             s_axis_tuser,  // frame_start
    input  logic                             s_axis_tlast,  // frame_end
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [drnpt_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // nearest_mm, speed_mm_s, zero pad
    output logic [drnpt_pkg::M_TUSER_W-1:0]  m_axis_tuser   // target_found, door_open
);
    import drnpt_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // controller
    drnpt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    // datapath
    drnpt_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cmd         (w_cmd),
        .o_status      (w_status)
    );

endmodule
